### hdl/ata_pio_pkg.sv
// package: constants, port and command codes, identify table for the ata pio disk port
`default_nettype none
package ata_pio_pkg;

  localparam int unsigned DISK_BYTES = 65536;
  localparam int unsigned ADDR_W     = $clog2(DISK_BYTES);
  localparam int unsigned OFFSET_W   = 9;
  localparam int unsigned SECTOR_W   = 32;
  localparam int unsigned LIN_W      = SECTOR_W + OFFSET_W;

  localparam logic [7:0] STATUS_READY = 8'h40;
  localparam logic [7:0] CMD_READ     = 8'h20;
  localparam logic [7:0] CMD_WRITE    = 8'h30;
  localparam logic [7:0] CMD_IDENTIFY = 8'hEC;

  localparam logic FUNC_READ  = 1'b0;
  localparam logic FUNC_WRITE = 1'b1;

  localparam logic [2:0] PORT_DATA  = 3'd0;
  localparam logic [2:0] PORT_FEAT  = 3'd1;
  localparam logic [2:0] PORT_COUNT = 3'd2;
  localparam logic [2:0] PORT_LBA0  = 3'd3;
  localparam logic [2:0] PORT_LBA1  = 3'd4;
  localparam logic [2:0] PORT_LBA2  = 3'd5;
  localparam logic [2:0] PORT_DRIVE = 3'd6;
  localparam logic [2:0] PORT_CMD   = 3'd7;

  localparam logic [2:0] MAX_BYTES = 3'd4;

  function automatic logic [31:0] ident_word(input logic [6:0] addr);
    logic [31:0] w;
    case (addr)
      7'd0:  w = 32'h00090040;
      7'd1:  w = 32'h00100000;
      7'd2:  w = 32'h02007e00;
      7'd3:  w = 32'h0000003f;
      7'd5:  w = 32'h3030514d;
      7'd6:  w = 32'h31203030;
      7'd7, 7'd8, 7'd9: w = 32'h20202020;
      7'd10: w = 32'h02000003;
      7'd11: w = 32'h322e0004;
      7'd12: w = 32'h2020352b;
      7'd13: w = 32'h51452020;
      7'd14: w = 32'h20484d55;
      7'd15: w = 32'h44444152;
      7'd16: w = 32'h4b204953;
      7'd17, 7'd18, 7'd19, 7'd20, 7'd21, 7'd22: w = 32'h20202020;
      7'd23: w = 32'h80102020;
      7'd24: w = 32'h0b000001;
      7'd25: w = 32'h02000000;
      7'd26: w = 32'h00070200;
      7'd27: w = 32'h00100009;
      7'd28: w = 32'h2370003f;
      7'd29: w = 32'h01100000;
      7'd30: w = 32'h00002710;
      7'd31: w = 32'h00070007;
      7'd32: w = 32'h00780003;
      7'd33: w = 32'h00780078;
      7'd34: w = 32'h40000078;
      7'd40: w = 32'h001600f0;
      7'd41: w = 32'h74004021;
      7'd42: w = 32'h40214000;
      7'd43: w = 32'h40003400;
      7'd44: w = 32'h0000203f;
      7'd46: w = 32'h60010000;
      7'd50: w = 32'h00002710;
      7'd53: w = 32'h00006000;
      7'd84: w = 32'h00010000;
      default: w = 32'h00000000;
    endcase
    return w;
  endfunction

endpackage
`default_nettype wire

### hdl/ata_pio_disk_port_model.sv
// top level: ata pio disk port with byte sequencer and disk store
//
// channel  | dir | ports                                          | transfer when
// command  | in  | func_i port_i access_size_i write_data_i       | start_i && !busy_o
// result   | out | read_data_o error_o                            | done_o (one cycle)
//
// register, status and error accesses: go from accept straight to the done state.
// data port accesses: the transfer state walks 0 to 4 bytes, then the done state; each
// byte uses the shared sector/offset incrementer, disk r/w bytes the single store port.
// after reset the 65536-byte disk store is cleared one byte a cycle, busy_o high.
// the receiver cannot stall; a new command is taken in the cycle the strobe shows.
`default_nettype none
module ata_pio_disk_port_model (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        start_i,
  output logic             busy_o,
  input  wire logic        func_i,
  input  wire logic [2:0]  port_i,
  input  wire logic [2:0]  access_size_i,
  input  wire logic [31:0] write_data_i,
  output logic             done_o,
  output logic [31:0]      read_data_o,
  output logic             error_o
);

  localparam int unsigned AW = ata_pio_pkg::ADDR_W;
  localparam int unsigned OW = ata_pio_pkg::OFFSET_W;
  localparam int unsigned SW = ata_pio_pkg::SECTOR_W;
  localparam int unsigned LW = ata_pio_pkg::LIN_W;

  typedef enum logic [3:0] {
    ST_CLEAR = 4'b0001,
    ST_IDLE  = 4'b0010,
    ST_XFER  = 4'b0100,
    ST_DONE  = 4'b1000
  } state_e;

  typedef enum logic [1:0] {
    MODE_ID,
    MODE_RD,
    MODE_WR
  } mode_e;

  state_e          state_q, state_d;
  mode_e           mode_q, mode_d;
  logic [SW-1:0]   sector_q, sector_d;
  logic [OW-1:0]   offset_q, offset_d;
  logic [7:0]      cmd_q, cmd_d;
  logic [AW-1:0]   clr_q, clr_d;
  logic [31:0]     wdata_q, wdata_d;
  logic [2:0]      nbytes_q, nbytes_d;
  logic [1:0]      idx_q, idx_d;
  logic [31:0]     rdata_q, rdata_d;
  logic            rd_pend_q, rd_pend_d;
  logic [1:0]      rd_idx_q, rd_idx_d;
  logic            err_q, err_d;
  logic            done_q, done_d;
  logic [31:0]     out_data_q, out_data_d;
  logic            out_err_q, out_err_d;

  logic [7:0]      mem [ata_pio_pkg::DISK_BYTES];
  logic [7:0]      mem_q;
  logic [AW-1:0]   mem_addr;
  logic            mem_we;
  logic [7:0]      mem_wdata;

  logic [LW-1:0]   lin;
  logic [LW-1:0]   lin_inc;
  logic [31:0]     rom_word;
  logic [31:0]     rom_sh;
  logic [31:0]     wd_sh;
  logic [31:0]     rd_ins;
  logic [31:0]     rdata_merged;
  logic [2:0]      size_c;
  logic            accept;
  logic            last_byte;

  assign accept    = start_i && (state_q == ST_IDLE);
  assign size_c    = (access_size_i > ata_pio_pkg::MAX_BYTES) ? ata_pio_pkg::MAX_BYTES
                                                              : access_size_i;
  assign lin       = {sector_q, offset_q};
  assign lin_inc   = lin + LW'(1);
  assign rom_word  = ata_pio_pkg::ident_word(offset_q[OW-1:2]);
  assign rom_sh    = rom_word >> {offset_q[1:0], 3'b000};
  assign wd_sh     = wdata_q >> {idx_q, 3'b000};
  assign rd_ins    = {24'd0, mem_q} << {rd_idx_q, 3'b000};
  assign rdata_merged = rd_pend_q ? (rdata_q | rd_ins) : rdata_q;
  assign last_byte = (({1'b0, idx_q} + 3'd1) == nbytes_q);

  always_comb begin
    state_d    = state_q;
    mode_d     = mode_q;
    sector_d   = sector_q;
    offset_d   = offset_q;
    cmd_d      = cmd_q;
    clr_d      = clr_q;
    wdata_d    = wdata_q;
    nbytes_d   = nbytes_q;
    idx_d      = idx_q;
    rdata_d    = rdata_merged;
    rd_pend_d  = 1'b0;
    rd_idx_d   = rd_idx_q;
    err_d      = err_q;
    done_d     = 1'b0;
    out_data_d = out_data_q;
    out_err_d  = out_err_q;
    mem_addr   = lin[AW-1:0];
    mem_we     = 1'b0;
    mem_wdata  = wd_sh[7:0];

    case (state_q)
      ST_CLEAR: begin
        mem_addr  = clr_q;
        mem_we    = 1'b1;
        mem_wdata = 8'd0;
        clr_d     = AW'(clr_q + 1'b1);
        if (clr_q == {AW{1'b1}}) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (accept) begin
          rdata_d  = 32'd0;
          err_d    = 1'b0;
          wdata_d  = write_data_i;
          nbytes_d = size_c;
          idx_d    = 2'd0;
          state_d  = ST_DONE;
          if (func_i == ata_pio_pkg::FUNC_READ) begin
            if (port_i == ata_pio_pkg::PORT_CMD) begin
              rdata_d = {24'd0, ata_pio_pkg::STATUS_READY};
            end else if (port_i == ata_pio_pkg::PORT_DATA &&
                         cmd_q == ata_pio_pkg::CMD_IDENTIFY) begin
              mode_d = MODE_ID;
              if (size_c != 3'd0) state_d = ST_XFER;
            end else if (port_i == ata_pio_pkg::PORT_DATA &&
                         cmd_q == ata_pio_pkg::CMD_READ) begin
              mode_d = MODE_RD;
              if (size_c != 3'd0) state_d = ST_XFER;
            end else begin
              err_d = 1'b1;
            end
          end else begin
            case (port_i)
              ata_pio_pkg::PORT_DATA: begin
                if (cmd_q == ata_pio_pkg::CMD_WRITE) begin
                  mode_d = MODE_WR;
                  if (size_c != 3'd0) state_d = ST_XFER;
                end else begin
                  err_d = 1'b1;
                end
              end
              ata_pio_pkg::PORT_COUNT: begin
              end
              ata_pio_pkg::PORT_LBA0:  sector_d[7:0]   = write_data_i[7:0];
              ata_pio_pkg::PORT_LBA1:  sector_d[15:8]  = write_data_i[7:0];
              ata_pio_pkg::PORT_LBA2:  sector_d[23:16] = write_data_i[7:0];
              ata_pio_pkg::PORT_DRIVE: sector_d[31:24] = 8'd0;
              ata_pio_pkg::PORT_CMD: begin
                cmd_d    = write_data_i[7:0];
                offset_d = '0;
              end
              default: err_d = 1'b1;
            endcase
          end
        end
      end
      ST_XFER: begin
        idx_d = idx_q + 2'd1;
        case (mode_q)
          MODE_ID: begin
            rdata_d  = rdata_merged | ({24'd0, rom_sh[7:0]} << {idx_q, 3'b000});
            offset_d = lin_inc[OW-1:0];
          end
          MODE_RD: begin
            rd_pend_d = 1'b1;
            rd_idx_d  = idx_q;
            {sector_d, offset_d} = lin_inc;
          end
          MODE_WR: begin
            mem_we = 1'b1;
            {sector_d, offset_d} = lin_inc;
          end
          default: begin
          end
        endcase
        if (last_byte) state_d = ST_DONE;
      end
      ST_DONE: begin
        done_d     = 1'b1;
        out_data_d = rdata_merged;
        out_err_d  = err_q;
        state_d    = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_addr] <= mem_wdata;
    end
    mem_q <= mem[mem_addr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_CLEAR;
      sector_q  <= '0;
      offset_q  <= '0;
      cmd_q     <= '0;
      clr_q     <= '0;
      rd_pend_q <= 1'b0;
      done_q    <= 1'b0;
    end else begin
      state_q   <= state_d;
      sector_q  <= sector_d;
      offset_q  <= offset_d;
      cmd_q     <= cmd_d;
      clr_q     <= clr_d;
      rd_pend_q <= rd_pend_d;
      done_q    <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    mode_q     <= mode_d;
    wdata_q    <= wdata_d;
    nbytes_q   <= nbytes_d;
    idx_q      <= idx_d;
    rdata_q    <= rdata_d;
    rd_idx_q   <= rd_idx_d;
    err_q      <= err_d;
    out_data_q <= out_data_d;
    out_err_q  <= out_err_d;
  end

  assign busy_o      = (state_q != ST_IDLE);
  assign done_o      = done_q;
  assign read_data_o = out_data_q;
  assign error_o     = out_err_q;

  a_done_after_done_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(state_q == ST_DONE))
    else $error("result strobe without completion state");

  a_error_zero_data: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && error_o) |-> (read_data_o == 32'd0))
    else $error("errored access returned data");

  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o) |=> busy_o)
    else $error("not busy after accepted transfer");

  a_read_pending_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rd_pend_q |-> ($past(state_q == ST_XFER) && mode_q == MODE_RD))
    else $error("store read pending outside a disk read");

endmodule
`default_nettype wire
